// ===== hw/rtl/dorq_pkg.sv =====
// shared constants, codes and state type of the deadline ordered request queue
`timescale 1ns / 1ps
package dorq_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int K_W           = $clog2(MAX_RESULTS);
   localparam int CAP_RESET     = 10;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 5;

   localparam logic [62:0] TIME_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [1:0] FUNC_PEND    = 2'd0;
   localparam logic [1:0] FUNC_DELETE  = 2'd1;
   localparam logic [1:0] FUNC_SERVICE = 2'd2;

   localparam logic [2:0] ST_PENDED  = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_DELETED = 3'd2;
   localparam logic [2:0] ST_NO_SLOT = 3'd3;
   localparam logic [2:0] ST_SERVED  = 3'd4;
   localparam logic [2:0] ST_NOT_DUE = 3'd5;
   localparam logic [2:0] ST_EMPTY   = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_FIFO_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY  = 1'd1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_P_ORD, S_P_FT, S_P_CMP,
      S_UP_RD, S_UP_WR, S_P_PLACE,
      S_D_ORD, S_D_CMP,
      S_DN_RD, S_DN_WR,
      S_H_ORD, S_H_FT, S_H_SET,
      S_S_ORD, S_S_DAT, S_S_CAP
   } state_type;

endpackage

// ===== hw/rtl/deadline_ordered_request_queue.sv =====
// deadline ordered request queue: slot store, order list and service sequencer
//
// An item is a pend, delete or service command, taken when start is high and
// busy is low. Results come out on the rsp_ ports, one cycle each, marked by
// rsp_strobe; rsp_last marks the final word of a command. The receiver cannot
// stall, so results simply stream out as the sequencer produces them.
// A full queue, a delete of a free slot, an empty or not-due service answer
// in the cycle after start. In deadline order a pend walks the order memory,
// reading each entry ahead of its place and its fire time, then moves each
// entry behind its place one place back; in FIFO mode it appends at the tail.
// A delete scans the order list for the handle, shifts each entry behind it
// forward, and looks up a new head when it removed the head. A service fetches
// the head, then shifts and looks up a new head per entry served, up to 16
// per command (one in FIFO mode). The order memory's single read port paces these steps.
// Configuration writes on csr_ are always ready; write them while idle.
// Reset empties the queue, selects deadline order and sets capacity to 10;
// the slot memories keep their contents and are not cleared.
`timescale 1ns / 1ps
module deadline_ordered_request_queue #(
   parameter int SLOTS = dorq_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_func,
   input  logic [62:0]                     req_now,
   input  logic [31:0]                     req_delay,
   input  logic [31:0]                     req_payload,
   input  logic [31:0]                     req_tag,
   input  logic                            req_want_notify,
   input  logic [3:0]                      req_handle,
   output logic                            rsp_strobe,
   output logic [2:0]                      rsp_status,
   output logic [3:0]                      rsp_handle_res,
   output logic [31:0]                     rsp_payload_res,
   output logic [31:0]                     rsp_tag_res,
   output logic                            rsp_notify,
   output logic                            rsp_wake,
   output logic [62:0]                     rsp_next_due,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dorq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dorq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dorq_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int PW = SW + 1;
   localparam int DW = 65;

   state_type state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [62:0]      now_ff, now_in;
   logic [62:0]      t_ff, t_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [PW-1:0]    idx_ff, idx_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [31:0]      pay_ff, pay_in;
   logic [31:0]      tag_ff, tag_in;
   logic             nt_ff, nt_in;
   logic             wake_ff, wake_in;
   logic [PW-1:0]    pending_ff, pending_in;
   logic [SLOTS-1:0] busy_map_ff, busy_map_in;
   logic [62:0]      head_ff, head_in;
   logic             fifo_ff;
   logic [4:0]       cap_ff;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [3:0]  rsp_handle_ff, rsp_handle_in;
   logic [31:0] rsp_pay_ff, rsp_pay_in;
   logic [31:0] rsp_tag_ff, rsp_tag_in;
   logic        rsp_nt_ff, rsp_nt_in;
   logic        rsp_wake_ff, rsp_wake_in;
   logic [62:0] rsp_due_ff, rsp_due_in;
   logic        rsp_last_ff, rsp_last_in;

   // memory ports
   logic          ord_we, ord_re, ft_we, ft_re, dat_we, dat_re;
   logic [SW-1:0] ord_waddr, ord_raddr, ft_addr_w, ft_raddr, dat_waddr, dat_raddr;
   logic [SW-1:0] ord_wdata, ord_rdata;
   logic [62:0]   ft_wdata, ft_rdata;
   logic [DW-1:0] dat_wdata, dat_rdata;

   dorq_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_order (
      .clock(clock), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
      .re(ord_re), .raddr(ord_raddr), .rdata(ord_rdata)
   );
   dorq_ram #(.WIDTH(63), .DEPTH(SLOTS)) u_fire (
      .clock(clock), .we(ft_we), .waddr(ft_addr_w), .wdata(ft_wdata),
      .re(ft_re), .raddr(ft_raddr), .rdata(ft_rdata)
   );
   dorq_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_data (
      .clock(clock), .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
      .re(dat_re), .raddr(dat_raddr), .rdata(dat_rdata)
   );

   // lowest free slot
   logic [SW-1:0] free_idx;
   logic          free_any;
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy_map_ff[i]) begin
            free_idx = SW'(i);
            free_any = 1'b1;
         end
      end
   end

   logic [63:0] sum;
   logic [62:0] t_new;
   logic [7:0]  cap_eff;
   logic        q_full;
   logic        h_bad;
   assign sum     = {1'b0, req_now} + {32'b0, req_delay};
   assign t_new   = sum[63] ? TIME_MAX : sum[62:0];
   assign cap_eff = (8'(cap_ff) > 8'(SLOTS)) ? 8'(SLOTS) : 8'(cap_ff);
   assign q_full  = (8'(pending_ff) >= cap_eff) || !free_any;
   assign h_bad   = ({4'b0, req_handle} >= 8'(SLOTS)) || !busy_map_ff[SW'(req_handle)];

   logic          dn_go;
   logic [PW-1:0] dn_idx;
   logic          rm_end;
   logic          emit_rm;
   logic          serve_last;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      now_in      = now_ff;
      t_in        = t_ff;
      slot_in     = slot_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      k_in        = k_ff;
      pay_in      = pay_ff;
      tag_in      = tag_ff;
      nt_in       = nt_ff;
      wake_in     = wake_ff;
      pending_in  = pending_ff;
      busy_map_in = busy_map_ff;
      head_in     = head_ff;

      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_nt_in     = rsp_nt_ff;
      rsp_wake_in   = rsp_wake_ff;
      rsp_due_in    = rsp_due_ff;
      rsp_last_in   = rsp_last_ff;

      ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_re = 1'b0; ord_raddr = '0;
      ft_we = 1'b0;  ft_addr_w = '0; ft_wdata = '0;  ft_re = 1'b0;  ft_raddr = '0;
      dat_we = 1'b0; dat_waddr = '0; dat_wdata = '0; dat_re = 1'b0; dat_raddr = '0;

      dn_go      = 1'b0;
      dn_idx     = idx_ff;
      rm_end     = 1'b0;
      emit_rm    = 1'b0;
      serve_last = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_func;
               now_in = req_now;
               case (req_func)
                  FUNC_PEND: begin
                     if (q_full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_FULL;
                        rsp_handle_in = '0;
                        rsp_pay_in    = '0;
                        rsp_tag_in    = '0;
                        rsp_nt_in     = 1'b0;
                        rsp_wake_in   = 1'b0;
                        rsp_due_in    = head_ff;
                        rsp_last_in   = 1'b1;
                     end else begin
                        slot_in   = free_idx;
                        t_in      = t_new;
                        ft_we     = 1'b1;
                        ft_addr_w = free_idx;
                        ft_wdata  = t_new;
                        dat_we    = 1'b1;
                        dat_waddr = free_idx;
                        dat_wdata = {req_payload, req_tag, req_want_notify};
                        if (!fifo_ff && pending_ff != '0) begin
                           pos_in   = '0;
                           state_in = S_P_ORD;
                        end else begin
                           pos_in   = pending_ff;
                           state_in = S_P_PLACE;
                        end
                     end
                  end
                  FUNC_DELETE: begin
                     if (h_bad) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_NO_SLOT;
                        rsp_handle_in = req_handle;
                        rsp_pay_in    = '0;
                        rsp_tag_in    = '0;
                        rsp_nt_in     = 1'b0;
                        rsp_wake_in   = 1'b0;
                        rsp_due_in    = head_ff;
                        rsp_last_in   = 1'b1;
                     end else if (pending_ff == '0) begin
                        // busy but not listed: just free it
                        busy_map_in[SW'(req_handle)] = 1'b0;
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_DELETED;
                        rsp_handle_in = req_handle;
                        rsp_pay_in    = '0;
                        rsp_tag_in    = '0;
                        rsp_nt_in     = 1'b0;
                        rsp_wake_in   = 1'b0;
                        rsp_due_in    = head_ff;
                        rsp_last_in   = 1'b1;
                     end else begin
                        slot_in  = SW'(req_handle);
                        pos_in   = '0;
                        state_in = S_D_ORD;
                     end
                  end
                  FUNC_SERVICE: begin
                     if (pending_ff == '0 || (!fifo_ff && head_ff > req_now)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = (pending_ff == '0) ? ST_EMPTY : ST_NOT_DUE;
                        rsp_handle_in = '0;
                        rsp_pay_in    = '0;
                        rsp_tag_in    = '0;
                        rsp_nt_in     = 1'b0;
                        rsp_wake_in   = 1'b0;
                        rsp_due_in    = head_ff;
                        rsp_last_in   = 1'b1;
                     end else begin
                        k_in     = '0;
                        state_in = S_S_ORD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // insertion point: first entry firing later than the new one
         S_P_ORD: begin
            ord_re    = 1'b1;
            ord_raddr = pos_ff[SW-1:0];
            state_in  = S_P_FT;
         end
         S_P_FT: begin
            ft_re    = 1'b1;
            ft_raddr = ord_rdata;
            state_in = S_P_CMP;
         end
         S_P_CMP: begin
            if (ft_rdata > t_ff) begin
               idx_in   = pending_ff - 1'b1;
               state_in = S_UP_RD;
            end else if (pos_ff + 1'b1 == pending_ff) begin
               pos_in   = pending_ff;
               state_in = S_P_PLACE;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = S_P_ORD;
            end
         end
         S_UP_RD: begin
            ord_re    = 1'b1;
            ord_raddr = idx_ff[SW-1:0];
            state_in  = S_UP_WR;
         end
         S_UP_WR: begin
            ord_we    = 1'b1;
            ord_waddr = SW'(idx_ff + 1'b1);
            ord_wdata = ord_rdata;
            if (idx_ff == pos_ff) begin
               state_in = S_P_PLACE;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = S_UP_RD;
            end
         end
         S_P_PLACE: begin
            ord_we    = 1'b1;
            ord_waddr = pos_ff[SW-1:0];
            ord_wdata = slot_ff;
            pending_in = pending_ff + 1'b1;
            busy_map_in[slot_ff] = 1'b1;
            if (pos_ff == '0) begin
               head_in = t_ff;
            end
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_PENDED;
            rsp_handle_in = 4'(slot_ff);
            rsp_pay_in    = '0;
            rsp_tag_in    = '0;
            rsp_nt_in     = 1'b0;
            rsp_wake_in   = 1'b0;
            rsp_due_in    = (pos_ff == '0) ? t_ff : head_ff;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end

         // delete: find the handle in the order list
         S_D_ORD: begin
            ord_re    = 1'b1;
            ord_raddr = pos_ff[SW-1:0];
            state_in  = S_D_CMP;
         end
         S_D_CMP: begin
            if (ord_rdata == slot_ff) begin
               wake_in = !fifo_ff && (pos_ff == '0);
               dn_go   = 1'b1;
               dn_idx  = pos_ff;
            end else if (pos_ff + 1'b1 == pending_ff) begin
               busy_map_in[slot_ff] = 1'b0;
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_DELETED;
               rsp_handle_in = 4'(slot_ff);
               rsp_pay_in    = '0;
               rsp_tag_in    = '0;
               rsp_nt_in     = 1'b0;
               rsp_wake_in   = 1'b0;
               rsp_due_in    = head_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = S_D_ORD;
            end
         end

         // close the gap behind the removed position
         S_DN_RD: begin
            ord_re    = 1'b1;
            ord_raddr = SW'(idx_ff + 1'b1);
            state_in  = S_DN_WR;
         end
         S_DN_WR: begin
            ord_we    = 1'b1;
            ord_waddr = idx_ff[SW-1:0];
            ord_wdata = ord_rdata;
            dn_go     = 1'b1;
            dn_idx    = idx_ff + 1'b1;
         end

         // new head lookup
         S_H_ORD: begin
            ord_re    = 1'b1;
            ord_raddr = '0;
            state_in  = S_H_FT;
         end
         S_H_FT: begin
            ft_re    = 1'b1;
            ft_raddr = ord_rdata;
            state_in = S_H_SET;
         end
         S_H_SET: begin
            head_in = ft_rdata;
            emit_rm = 1'b1;
         end

         // service: fetch head entry
         S_S_ORD: begin
            ord_re    = 1'b1;
            ord_raddr = '0;
            state_in  = S_S_DAT;
         end
         S_S_DAT: begin
            dat_re    = 1'b1;
            dat_raddr = ord_rdata;
            slot_in   = ord_rdata;
            state_in  = S_S_CAP;
         end
         S_S_CAP: begin
            pay_in  = dat_rdata[64:33];
            tag_in  = dat_rdata[32:1];
            nt_in   = dat_rdata[0];
            wake_in = 1'b0;
            pos_in  = '0;
            dn_go   = 1'b1;
            dn_idx  = '0;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (dn_go) begin
         idx_in = dn_idx;
         if (dn_idx + 1'b1 < pending_ff) begin
            state_in = S_DN_RD;
         end else begin
            rm_end = 1'b1;
         end
      end

      // removal can finish in the cycle that found the entry
      if (rm_end) begin
         pending_in = pending_ff - 1'b1;
         busy_map_in[slot_ff] = 1'b0;
         if (pos_in == '0) begin
            if (pending_ff == PW'(1)) begin
               head_in = TIME_MAX;
               emit_rm = 1'b1;
            end else begin
               state_in = S_H_ORD;
            end
         end else begin
            emit_rm = 1'b1;
         end
      end

      if (emit_rm) begin
         rsp_strobe_in = 1'b1;
         rsp_handle_in = 4'(slot_ff);
         rsp_due_in    = head_in;
         if (op_ff == FUNC_SERVICE) begin
            serve_last = fifo_ff || (pending_in == '0) ||
                         (k_ff == K_W'(MAX_RESULTS - 1)) || (head_in > now_ff);
            rsp_status_in = ST_SERVED;
            rsp_pay_in    = pay_in;
            rsp_tag_in    = tag_in;
            rsp_nt_in     = nt_in;
            rsp_wake_in   = 1'b0;
            rsp_last_in   = serve_last;
            if (serve_last) begin
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_S_ORD;
            end
         end else begin
            rsp_status_in = ST_DELETED;
            rsp_pay_in    = '0;
            rsp_tag_in    = '0;
            rsp_nt_in     = 1'b0;
            rsp_wake_in   = wake_in;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pending_ff    <= '0;
         busy_map_ff   <= '0;
         head_ff       <= TIME_MAX;
         rsp_strobe_ff <= 1'b0;
         fifo_ff       <= 1'b0;
         cap_ff        <= 5'(CAP_RESET);
      end else begin
         state_ff      <= state_in;
         pending_ff    <= pending_in;
         busy_map_ff   <= busy_map_in;
         head_ff       <= head_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_FIFO_MODE: fifo_ff <= csr_wdata[0];
               CSR_CAPACITY:  cap_ff  <= csr_wdata[4:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      now_ff        <= now_in;
      t_ff          <= t_in;
      slot_ff       <= slot_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      pay_ff        <= pay_in;
      tag_ff        <= tag_in;
      nt_ff         <= nt_in;
      wake_ff       <= wake_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_nt_ff     <= rsp_nt_in;
      rsp_wake_ff   <= rsp_wake_in;
      rsp_due_ff    <= rsp_due_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_handle_res  = rsp_handle_ff;
   assign rsp_payload_res = rsp_pay_ff;
   assign rsp_tag_res     = rsp_tag_ff;
   assign rsp_notify      = rsp_nt_ff;
   assign rsp_wake        = rsp_wake_ff;
   assign rsp_next_due    = rsp_due_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== hw/rtl/dorq_ram.sv =====
// generic single write port, single read port ram with registered read data
`timescale 1ns / 1ps
module dorq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
